// ===== sv/pac_pkg.sv =====
package pac_pkg;

    // Field and datapath widths
    localparam int COORD_W = 16;
    localparam int SUMC_W  = 17;   // sum of two coordinates
    localparam int PROD_W  = 32;   // one coordinate product
    localparam int CR_W    = 33;   // edge cross term, Q.16
    localparam int MTERM_W = 50;   // cross term times coordinate sum, Q.24
    localparam int AREA_W  = 43;
    localparam int ABS_W   = 42;
    localparam int MOM_W   = 59;
    localparam int MABS_W  = 59;   // magnitude of a moment sum
    localparam int DIV_W   = 46;   // 6 * |area|
    localparam int NUM_W   = 61;   // 2 * |moment| + 3 * |area|
    localparam int REM_W   = 64;   // remainder and shifted divisor
    localparam int QUO_W   = 17;   // quotient bits kept below the overflow check
    localparam int STEP_W  = 5;
    localparam logic [STEP_W-1:0] DIV_STEPS = 5'd17;

    // Centroid saturation limits
    localparam logic [QUO_W-1:0]   Q_POS_LIMIT = 17'd32767;
    localparam logic [QUO_W-1:0]   Q_NEG_LIMIT = 17'd32768;
    localparam logic [COORD_W-1:0] CENT_POS_SAT = 16'h7FFF;
    localparam logic [COORD_W-1:0] CENT_NEG_SAT = 16'h8000;

    // Polygon queue between accumulator and divider
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Closed polygon sums handed to the back end
    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [MOM_W-1:0]  mom_x;
        logic [MOM_W-1:0]  mom_y;
        logic              ovf;
    } t_poly_sums;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ABS,
        BK_INIT,
        BK_DIV,
        BK_DONE
    } t_back_state;

endpackage

// ===== sv/pac_front.sv =====
module pac_front #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic signed [pac_pkg::COORD_W-1:0]   i_vertex_x,
    input  logic signed [pac_pkg::COORD_W-1:0]   i_vertex_y,
    input  logic                                 i_last,
    output logic                                 o_q_push,
    input  logic                                 i_q_full,
    output pac_pkg::t_poly_sums                  o_q_data
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // Vertex stage
    logic [CNT_W-1:0]                   r_count;
    logic signed [pac_pkg::COORD_W-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic                               r_close, r_close_start, r_close_ovf;

    // Edge stage
    logic                               r_b_valid, r_b_start, r_b_end, r_b_ovf;
    logic signed [pac_pkg::COORD_W-1:0] r_b_ax, r_b_ay, r_b_bx, r_b_by;

    // Cross term stage
    logic                               r_c_valid, r_c_start, r_c_end, r_c_ovf;
    logic signed [pac_pkg::CR_W-1:0]    r_c_cr;
    logic signed [pac_pkg::SUMC_W-1:0]  r_c_sx, r_c_sy;

    // Moment term stage
    logic                               r_d_valid, r_d_start, r_d_end, r_d_ovf;
    logic signed [pac_pkg::CR_W-1:0]    r_d_cr;
    logic signed [pac_pkg::MTERM_W-1:0] r_d_mx, r_d_my;

    // Running sums
    logic [pac_pkg::AREA_W-1:0]         r_area;
    logic [pac_pkg::MOM_W-1:0]          r_mom_x, r_mom_y;

    logic                               w_adv, w_accept, w_ovf;
    logic [CNT_W-1:0]                   w_cnt_inc, n_count;
    logic signed [pac_pkg::PROD_W-1:0]  w_p1, w_p2;
    logic signed [pac_pkg::MTERM_W-1:0] w_mx, w_my;
    logic [pac_pkg::AREA_W-1:0]         n_area;
    logic [pac_pkg::MOM_W-1:0]          n_mom_x, n_mom_y;

    // Pipeline holds only when a closed polygon cannot enter the queue
    assign w_adv    = !(r_d_valid && r_d_end && i_q_full);
    assign o_full   = !w_adv || r_close;
    assign w_accept = i_push && !o_full;

    // Vertex count, saturating one past the limit
    always_comb begin
        if (r_count == '0) begin
            w_cnt_inc = CNT_ONE;
        end else if (r_count <= CNT_MAX) begin
            w_cnt_inc = r_count + CNT_ONE;
        end else begin
            w_cnt_inc = r_count;
        end
        w_ovf   = (w_cnt_inc > CNT_MAX);
        n_count = i_last ? '0 : w_cnt_inc;
    end

    // Vertex stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_close   <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (w_adv) begin
            if (r_close) begin
                r_close   <= 1'b0;
                r_b_valid <= 1'b1;
            end else if (w_accept) begin
                r_count   <= n_count;
                r_close   <= i_last;
                r_b_valid <= (r_count != '0);
            end else begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // Vertex stage payload: edge to previous vertex, or closing edge to first
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_close) begin
                r_b_ax    <= r_prev_x;
                r_b_ay    <= r_prev_y;
                r_b_bx    <= r_first_x;
                r_b_by    <= r_first_y;
                r_b_start <= r_close_start;
                r_b_end   <= 1'b1;
                r_b_ovf   <= r_close_ovf;
            end else if (w_accept) begin
                if (r_count == '0) begin
                    r_first_x <= i_vertex_x;
                    r_first_y <= i_vertex_y;
                end
                r_prev_x      <= i_vertex_x;
                r_prev_y      <= i_vertex_y;
                r_b_ax        <= r_prev_x;
                r_b_ay        <= r_prev_y;
                r_b_bx        <= i_vertex_x;
                r_b_by        <= i_vertex_y;
                r_b_start     <= (r_count == CNT_ONE);
                r_b_end       <= 1'b0;
                r_b_ovf       <= 1'b0;
                r_close_start <= (r_count == '0);
                r_close_ovf   <= w_ovf;
            end
        end
    end

    // Cross term: ax*by - bx*ay
    assign w_p1 = r_b_ax * r_b_by;
    assign w_p2 = r_b_bx * r_b_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (w_adv) begin
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_cr    <= pac_pkg::CR_W'(w_p1) - pac_pkg::CR_W'(w_p2);
            r_c_sx    <= pac_pkg::SUMC_W'(r_b_ax) + pac_pkg::SUMC_W'(r_b_bx);
            r_c_sy    <= pac_pkg::SUMC_W'(r_b_ay) + pac_pkg::SUMC_W'(r_b_by);
            r_c_start <= r_b_start;
            r_c_end   <= r_b_end;
            r_c_ovf   <= r_b_ovf;
        end
    end

    // Moment terms
    assign w_mx = r_c_cr * r_c_sx;
    assign w_my = r_c_cr * r_c_sy;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_cr    <= r_c_cr;
            r_d_mx    <= w_mx;
            r_d_my    <= w_my;
            r_d_start <= r_c_start;
            r_d_end   <= r_c_end;
            r_d_ovf   <= r_c_ovf;
        end
    end

    // Accumulate; the first edge of a polygon restarts the sums
    always_comb begin
        n_area  = pac_pkg::AREA_W'(r_d_cr);
        n_mom_x = pac_pkg::MOM_W'(r_d_mx);
        n_mom_y = pac_pkg::MOM_W'(r_d_my);
        if (!r_d_start) begin
            n_area  = n_area + r_area;
            n_mom_x = n_mom_x + r_mom_x;
            n_mom_y = n_mom_y + r_mom_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_d_valid) begin
            r_area  <= n_area;
            r_mom_x <= n_mom_x;
            r_mom_y <= n_mom_y;
        end
    end

    // Closed polygon goes to the queue
    assign o_q_push       = r_d_valid && r_d_end && !i_q_full;
    assign o_q_data.area  = n_area;
    assign o_q_data.mom_x = n_mom_x;
    assign o_q_data.mom_y = n_mom_y;
    assign o_q_data.ovf   = r_d_ovf;

endmodule

// ===== sv/pac_fifo.sv =====
module pac_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pac_pkg::t_poly_sums i_data,
    output logic                o_full,
    input  logic                i_pop,
    output pac_pkg::t_poly_sums o_data,
    output logic                o_empty
);

    pac_pkg::t_poly_sums               r_mem [pac_pkg::Q_DEPTH];
    logic [pac_pkg::Q_PTR_W-1:0]       r_wr_ptr, r_rd_ptr;
    logic [pac_pkg::Q_CNT_W-1:0]       r_cnt;
    logic                              w_wr, w_rd;

    assign o_full  = (r_cnt == pac_pkg::Q_CNT_W'(pac_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== sv/pac_back.sv =====
module pac_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    output logic                                o_q_pop,
    input  pac_pkg::t_poly_sums                 i_q_data,
    input  logic                                i_pop,
    output logic                                o_empty,
    output logic signed [pac_pkg::AREA_W-1:0]   o_double_signed_area,
    output logic [pac_pkg::ABS_W-1:0]           o_double_area_abs,
    output logic signed [pac_pkg::COORD_W-1:0]  o_centroid_x,
    output logic signed [pac_pkg::COORD_W-1:0]  o_centroid_y,
    output logic                                o_degenerate,
    output logic                                o_overflow
);

    pac_pkg::t_back_state               r_state, n_state;
    pac_pkg::t_poly_sums                r_sums;

    logic [pac_pkg::AREA_W-1:0]         r_aa;
    logic [pac_pkg::MABS_W-1:0]         r_mxa, r_mya;
    logic                               r_neg_x, r_neg_y, r_degen;
    logic [pac_pkg::REM_W-1:0]          r_rem_x, r_rem_y, r_dsh;
    logic [pac_pkg::QUO_W-1:0]          r_q_x, r_q_y;
    logic                               r_over_x, r_over_y;
    logic [pac_pkg::STEP_W-1:0]         r_step;
    logic                               r_out_valid;

    logic                               w_ge_x, w_ge_y, w_out_load;
    logic [pac_pkg::DIV_W-1:0]          w_div;
    logic [pac_pkg::NUM_W-1:0]          w_num_x, w_num_y;

    // Rounded quotient to Q7.8 with sign and saturation
    function automatic logic [pac_pkg::COORD_W-1:0] sat_cent(
        input logic [pac_pkg::QUO_W-1:0] q,
        input logic                      over,
        input logic                      neg
    );
        logic [pac_pkg::QUO_W-1:0] negq;
        negq = '0 - q;
        if (neg) begin
            if (over || (q > pac_pkg::Q_NEG_LIMIT)) begin
                sat_cent = pac_pkg::CENT_NEG_SAT;
            end else begin
                sat_cent = negq[pac_pkg::COORD_W-1:0];
            end
        end else begin
            if (over || (q > pac_pkg::Q_POS_LIMIT)) begin
                sat_cent = pac_pkg::CENT_POS_SAT;
            end else begin
                sat_cent = q[pac_pkg::COORD_W-1:0];
            end
        end
    endfunction

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pac_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and queue pop
    always_comb begin
        n_state    = r_state;
        o_q_pop    = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            pac_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = pac_pkg::BK_ABS;
                end
            end
            pac_pkg::BK_ABS: begin
                n_state = pac_pkg::BK_INIT;
            end
            pac_pkg::BK_INIT: begin
                n_state = pac_pkg::BK_DIV;
            end
            pac_pkg::BK_DIV: begin
                if (r_step == '0) begin
                    n_state = pac_pkg::BK_DONE;
                end
            end
            pac_pkg::BK_DONE: begin
                if (!r_out_valid || i_pop) begin
                    w_out_load = 1'b1;
                    n_state    = pac_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = pac_pkg::BK_IDLE;
            end
        endcase
    end

    // Divisor 6*|A| and numerators 2*|M| + 3*|A|
    assign w_div   = (pac_pkg::DIV_W'(r_aa) << 1) + (pac_pkg::DIV_W'(r_aa) << 2);
    assign w_num_x = (pac_pkg::NUM_W'(r_mxa) << 1) + pac_pkg::NUM_W'(r_aa)
                   + (pac_pkg::NUM_W'(r_aa) << 1);
    assign w_num_y = (pac_pkg::NUM_W'(r_mya) << 1) + pac_pkg::NUM_W'(r_aa)
                   + (pac_pkg::NUM_W'(r_aa) << 1);

    assign w_ge_x = (r_rem_x >= r_dsh);
    assign w_ge_y = (r_rem_y >= r_dsh);

    // Divider datapath: both centroid lanes share the shifted divisor
    always_ff @(posedge i_clk) begin
        case (r_state)
            pac_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    r_sums <= i_q_data;
                end
            end
            pac_pkg::BK_ABS: begin
                r_aa    <= r_sums.area[pac_pkg::AREA_W-1] ? ('0 - r_sums.area) : r_sums.area;
                r_mxa   <= r_sums.mom_x[pac_pkg::MOM_W-1] ? ('0 - r_sums.mom_x) : r_sums.mom_x;
                r_mya   <= r_sums.mom_y[pac_pkg::MOM_W-1] ? ('0 - r_sums.mom_y) : r_sums.mom_y;
                r_neg_x <= r_sums.mom_x[pac_pkg::MOM_W-1] ^ r_sums.area[pac_pkg::AREA_W-1];
                r_neg_y <= r_sums.mom_y[pac_pkg::MOM_W-1] ^ r_sums.area[pac_pkg::AREA_W-1];
                r_degen <= (r_sums.area == '0);
            end
            pac_pkg::BK_INIT: begin
                r_rem_x <= pac_pkg::REM_W'(w_num_x);
                r_rem_y <= pac_pkg::REM_W'(w_num_y);
                r_dsh   <= pac_pkg::REM_W'(w_div) << pac_pkg::DIV_STEPS;
                r_step  <= pac_pkg::DIV_STEPS;
                r_q_x   <= '0;
                r_q_y   <= '0;
            end
            pac_pkg::BK_DIV: begin
                // First step only checks whether the quotient exceeds 17 bits
                if (r_step == pac_pkg::DIV_STEPS) begin
                    r_over_x <= w_ge_x;
                    r_over_y <= w_ge_y;
                end else begin
                    r_q_x <= {r_q_x[pac_pkg::QUO_W-2:0], w_ge_x};
                    r_q_y <= {r_q_y[pac_pkg::QUO_W-2:0], w_ge_y};
                    if (w_ge_x) begin
                        r_rem_x <= r_rem_x - r_dsh;
                    end
                    if (w_ge_y) begin
                        r_rem_y <= r_rem_y - r_dsh;
                    end
                end
                r_dsh  <= r_dsh >> 1;
                r_step <= r_step - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_double_signed_area <= r_sums.area;
            o_double_area_abs    <= r_aa[pac_pkg::ABS_W-1:0];
            o_centroid_x         <= r_degen ? '0 : sat_cent(r_q_x, r_over_x, r_neg_x);
            o_centroid_y         <= r_degen ? '0 : sat_cent(r_q_y, r_over_y, r_neg_y);
            o_degenerate         <= r_degen;
            o_overflow           <= r_sums.ovf;
        end
    end

    assign o_empty = !r_out_valid;

endmodule

// ===== sv/polygon_area_centroid_top.sv =====
// Shoelace polygon area and centroid. Vertices (signed Q7.8) are pushed one per
// request; last closes the polygon to its first vertex and yields one result:
// twice the signed area, its magnitude, the centroid rounded to nearest (ties
// away from zero) and saturated to Q7.8, a degenerate flag for zero area and
// an overflow flag past MAX_VERTICES vertices. The front accumulator takes one
// vertex per cycle while full is low; the closing edge holds full high, and
// the sums pass the edge, cross term and moment term registers before they
// reach the two-entry polygon queue. The back end divides both moments in
// parallel with a restoring divider, one quotient bit per cycle, and finishes
// one polygon before it pops the next; polygons that arrive faster are
// throttled by the divider once the queue fills.
module polygon_area_centroid_top #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [pac_pkg::COORD_W-1:0]  i_vertex_x,
    input  logic signed [pac_pkg::COORD_W-1:0]  i_vertex_y,
    input  logic                                i_last,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [pac_pkg::AREA_W-1:0]   o_double_signed_area,
    output logic [pac_pkg::ABS_W-1:0]           o_double_area_abs,
    output logic signed [pac_pkg::COORD_W-1:0]  o_centroid_x,
    output logic signed [pac_pkg::COORD_W-1:0]  o_centroid_y,
    output logic                                o_degenerate,
    output logic                                o_overflow
);

    pac_pkg::t_poly_sums w_q_in, w_q_out;
    logic                w_q_push, w_q_full, w_q_pop, w_q_empty;

    // Vertex accumulator
    pac_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_vertex_x (i_vertex_x),
        .i_vertex_y (i_vertex_y),
        .i_last     (i_last),
        .o_q_push   (w_q_push),
        .i_q_full   (w_q_full),
        .o_q_data   (w_q_in)
    );

    // Closed polygon queue
    pac_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    // Centroid divider and result register
    pac_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_q_empty            (w_q_empty),
        .o_q_pop              (w_q_pop),
        .i_q_data             (w_q_out),
        .i_pop                (pop),
        .o_empty              (empty),
        .o_double_signed_area (o_double_signed_area),
        .o_double_area_abs    (o_double_area_abs),
        .o_centroid_x         (o_centroid_x),
        .o_centroid_y         (o_centroid_y),
        .o_degenerate         (o_degenerate),
        .o_overflow           (o_overflow)
    );

    // Queue is never written while full nor read while empty
    a_q_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("polygon queue written while full");

    a_q_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("polygon queue read while empty");

    // Degenerate flag tracks zero area, and then the centroid is zero
    a_degen_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_degenerate == (o_double_signed_area == '0)))
        else $error("degenerate flag disagrees with area");

    a_degen_centroid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_degenerate) |-> (o_centroid_x == '0 && o_centroid_y == '0))
        else $error("degenerate result has nonzero centroid");

endmodule
